// ===== rtl/core/mstc_pkg.sv =====
// Shared constants, types and codes for the magnetometer self-test checker.
package mstc_pkg;

    localparam int SAMPLES  = 5;                 // samples averaged per kind, 1..7
    localparam int AXES     = 3;
    localparam int SAMPLE_W = 16;
    localparam int LIMIT_W  = 16;
    localparam int DELTA_W  = 16;
    localparam int SUM_W    = 19;                // signed sum of up to 7 samples
    localparam int CNT_W    = 3;
    localparam int MAG_W    = SUM_W - 1;         // |sum|
    localparam int QUOT_W   = 16;                // |sum| / SAMPLES, up to 32768
    localparam int AVG_W    = QUOT_W + 1;        // signed average
    localparam int DIFF_W   = AVG_W + 1;         // signed difference of averages

    // reciprocal multiply: floor(a / SAMPLES) == (a * RECIP_M) >> RECIP_K for a < 2**MAG_W
    localparam int RECIP_K  = 24;
    localparam int RECIP_W  = RECIP_K + 1;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(((2 ** RECIP_K) + SAMPLES - 1) / SAMPLES);
    localparam int PROD_W   = MAG_W + RECIP_W;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SAMPLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

    // config register indexes
    localparam logic [1:0] REG_MIN_XY = 2'd0;
    localparam logic [1:0] REG_MAX_XY = 2'd1;
    localparam logic [1:0] REG_MIN_Z  = 2'd2;
    localparam logic [1:0] REG_MAX_Z  = 2'd3;

    localparam logic [LIMIT_W-1:0] MIN_XY_RST = 16'd2281;
    localparam logic [LIMIT_W-1:0] MAX_XY_RST = 16'd6843;
    localparam logic [LIMIT_W-1:0] MIN_Z_RST  = 16'd228;
    localparam logic [LIMIT_W-1:0] MAX_Z_RST  = 16'd2281;

    // failing axis codes
    localparam logic [1:0] FAIL_NONE = 2'd0;
    localparam logic [1:0] FAIL_X    = 2'd1;
    localparam logic [1:0] FAIL_Y    = 2'd2;
    localparam logic [1:0] FAIL_Z    = 2'd3;

    typedef enum logic [1:0] {
        S_COLLECT,
        S_DIVIDE,
        S_DIFF,
        S_JUDGE
    } t_state;

    typedef struct packed {
        logic acc_base;
        logic acc_stim;
        logic clear;
        logic divide;
        logic diff;
    } t_lane_ctl;

    typedef struct packed {
        logic [LIMIT_W-1:0] min_xy;
        logic [LIMIT_W-1:0] max_xy;
        logic [LIMIT_W-1:0] min_z;
        logic [LIMIT_W-1:0] max_z;
    } t_limits;

endpackage

// ===== rtl/core/mstc_lane.sv =====
// One axis lane: sums both sample kinds, divides by SAMPLES and forms |difference|.
module mstc_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mstc_pkg::t_lane_ctl                 i_ctl,
    input  logic signed [mstc_pkg::SAMPLE_W-1:0] i_sample,
    output logic [mstc_pkg::DELTA_W-1:0]        o_delta
);
    import mstc_pkg::*;

    logic signed [SUM_W-1:0]  r_base_sum;
    logic signed [SUM_W-1:0]  r_stim_sum;
    logic [QUOT_W-1:0]        r_base_q;
    logic [QUOT_W-1:0]        r_stim_q;
    logic                     r_base_neg;
    logic                     r_stim_neg;
    logic [DELTA_W-1:0]       r_delta;

    logic [MAG_W-1:0]         mag_base;
    logic [MAG_W-1:0]         mag_stim;
    logic [PROD_W-1:0]        prod_base;
    logic [PROD_W-1:0]        prod_stim;
    logic signed [AVG_W-1:0]  avg_base;
    logic signed [AVG_W-1:0]  avg_stim;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_sum <= '0;
            r_stim_sum <= '0;
        end else if (i_ctl.clear) begin
            r_base_sum <= '0;
            r_stim_sum <= '0;
        end else begin
            if (i_ctl.acc_base) begin
                r_base_sum <= r_base_sum + SUM_W'(i_sample);
            end
            if (i_ctl.acc_stim) begin
                r_stim_sum <= r_stim_sum + SUM_W'(i_sample);
            end
        end
    end

    // truncation toward zero: divide the magnitude, restore the sign later
    always_comb begin
        mag_base  = r_base_sum[SUM_W-1] ? MAG_W'(-r_base_sum) : MAG_W'(r_base_sum);
        mag_stim  = r_stim_sum[SUM_W-1] ? MAG_W'(-r_stim_sum) : MAG_W'(r_stim_sum);
        prod_base = PROD_W'(mag_base) * PROD_W'(RECIP_M);
        prod_stim = PROD_W'(mag_stim) * PROD_W'(RECIP_M);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.divide) begin
            r_base_q   <= prod_base[RECIP_K +: QUOT_W];
            r_stim_q   <= prod_stim[RECIP_K +: QUOT_W];
            r_base_neg <= r_base_sum[SUM_W-1];
            r_stim_neg <= r_stim_sum[SUM_W-1];
        end
    end

    always_comb begin
        avg_base = r_base_neg ? -signed'(AVG_W'(r_base_q)) : signed'(AVG_W'(r_base_q));
        avg_stim = r_stim_neg ? -signed'(AVG_W'(r_stim_q)) : signed'(AVG_W'(r_stim_q));
        diff     = DIFF_W'(avg_stim) - DIFF_W'(avg_base);
        diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.diff) begin
            r_delta <= diff_abs[DELTA_W-1:0];
        end
    end

    assign o_delta = r_delta;

endmodule

// ===== rtl/core/mstc_merge.sv =====
// Merge stage: window checks of the three lane deltas and the verdict output register.
module mstc_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  mstc_pkg::t_limits             i_limits,
    input  logic [mstc_pkg::DELTA_W-1:0]  i_delta_x,
    input  logic [mstc_pkg::DELTA_W-1:0]  i_delta_y,
    input  logic [mstc_pkg::DELTA_W-1:0]  i_delta_z,
    input  logic                          i_out_ready,
    output logic                          o_free,
    output logic                          o_out_valid,
    output logic                          o_passed,
    output logic [1:0]                    o_failed_axis,
    output logic [mstc_pkg::DELTA_W-1:0]  o_delta_x,
    output logic [mstc_pkg::DELTA_W-1:0]  o_delta_y,
    output logic [mstc_pkg::DELTA_W-1:0]  o_delta_z
);
    import mstc_pkg::*;

    logic               r_valid;
    logic               r_passed;
    logic [1:0]         r_fail;
    logic [DELTA_W-1:0] r_dx;
    logic [DELTA_W-1:0] r_dy;
    logic [DELTA_W-1:0] r_dz;
    logic [1:0]         fail;

    always_comb begin
        priority if (i_delta_x < i_limits.min_xy || i_delta_x > i_limits.max_xy) begin
            fail = FAIL_X;
        end else if (i_delta_y < i_limits.min_xy || i_delta_y > i_limits.max_xy) begin
            fail = FAIL_Y;
        end else if (i_delta_z < i_limits.min_z || i_delta_z > i_limits.max_z) begin
            fail = FAIL_Z;
        end else begin
            fail = FAIL_NONE;
        end
    end

    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load && o_free) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_passed <= (fail == FAIL_NONE);
            r_fail   <= fail;
            r_dx     <= i_delta_x;
            r_dy     <= i_delta_y;
            r_dz     <= i_delta_z;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_passed      = r_passed;
    assign o_failed_axis = r_fail;
    assign o_delta_x     = r_dx;
    assign o_delta_y     = r_dy;
    assign o_delta_z     = r_dz;

endmodule

// ===== rtl/core/magnetometer_self_test_checker.sv =====
// Top level of the magnetometer self-test checker: control, config registers, lanes, merge.
//
// Input channel (i_in_valid / o_in_ready) takes one three-axis sample word per
// cycle, tagged by i_kind as baseline (0) or stimulated (1). The first SAMPLES
// baseline words and then the first SAMPLES stimulated words are summed per
// axis in three lanes; other words are accepted and dropped.
// The last stimulated word starts the verdict: the reciprocal multiply in each
// lane (S_DIVIDE), then the averages' absolute difference (S_DIFF), then the
// window checks in the merge stage (S_JUDGE), each ending in a register. The
// verdict word is then valid on o_out_valid; the sums and counts clear.
// While a verdict is in progress o_in_ready is low; at all other times one
// sample word is taken per cycle.
// The verdict sits in an output register: while the receiver stalls, samples
// keep being taken, and only a following verdict waits in its last stage
// (input held off) until the register frees up.
// Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) land in the limit registers; write
// them only while no verdict is in progress.
// Synchronous reset restores default limits and clears sums, counts and output.
module magnetometer_self_test_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [mstc_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic signed [mstc_pkg::SAMPLE_W-1:0] i_x_sample,
    input  logic signed [mstc_pkg::SAMPLE_W-1:0] i_y_sample,
    input  logic signed [mstc_pkg::SAMPLE_W-1:0] i_z_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_passed,
    output logic [1:0]                    o_failed_axis,
    output logic [mstc_pkg::DELTA_W-1:0]  o_delta_x,
    output logic [mstc_pkg::DELTA_W-1:0]  o_delta_y,
    output logic [mstc_pkg::DELTA_W-1:0]  o_delta_z
);
    import mstc_pkg::*;

    t_state           r_state;
    t_state           n_state;
    t_limits          r_limits;
    logic [CNT_W-1:0] r_base_cnt;
    logic [CNT_W-1:0] r_stim_cnt;

    t_lane_ctl        lane_ctl;
    logic             accept;
    logic             take_base;
    logic             take_stim;
    logic             last_stim;
    logic             merge_load;
    logic             merge_free;
    logic [DELTA_W-1:0] delta_x;
    logic [DELTA_W-1:0] delta_y;
    logic [DELTA_W-1:0] delta_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.min_xy <= MIN_XY_RST;
            r_limits.max_xy <= MAX_XY_RST;
            r_limits.min_z  <= MIN_Z_RST;
            r_limits.max_z  <= MAX_Z_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_XY: r_limits.min_xy <= i_cfg_data;
                REG_MAX_XY: r_limits.max_xy <= i_cfg_data;
                REG_MIN_Z:  r_limits.min_z  <= i_cfg_data;
                REG_MAX_Z:  r_limits.max_z  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept    = i_in_valid && o_in_ready;
    assign take_base = accept && !i_kind && (r_base_cnt != CNT_FULL);
    assign take_stim = accept && i_kind && (r_base_cnt == CNT_FULL)
                       && (r_stim_cnt != CNT_FULL);
    assign last_stim = take_stim && (r_stim_cnt == CNT_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_cnt <= '0;
            r_stim_cnt <= '0;
        end else if (lane_ctl.clear) begin
            r_base_cnt <= '0;
            r_stim_cnt <= '0;
        end else begin
            if (take_base) begin
                r_base_cnt <= r_base_cnt + CNT_W'(1);
            end
            if (take_stim) begin
                r_stim_cnt <= r_stim_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: if (last_stim) n_state = S_DIVIDE;
            S_DIVIDE:  n_state = S_DIFF;
            S_DIFF:    n_state = S_JUDGE;
            S_JUDGE:   if (merge_free) n_state = S_COLLECT;
            default:   n_state = S_COLLECT;
        endcase
    end

    always_comb begin
        o_in_ready        = (r_state == S_COLLECT);
        lane_ctl.acc_base = take_base;
        lane_ctl.acc_stim = take_stim;
        lane_ctl.divide   = (r_state == S_DIVIDE);
        lane_ctl.clear    = (r_state == S_DIVIDE);   // quotients latch at the same edge
        lane_ctl.diff     = (r_state == S_DIFF);
        merge_load        = (r_state == S_JUDGE);
    end

    mstc_lane u_lane_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_x_sample),
        .o_delta  (delta_x)
    );

    mstc_lane u_lane_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_y_sample),
        .o_delta  (delta_y)
    );

    mstc_lane u_lane_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_sample (i_z_sample),
        .o_delta  (delta_z)
    );

    mstc_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (merge_load),
        .i_limits      (r_limits),
        .i_delta_x     (delta_x),
        .i_delta_y     (delta_y),
        .i_delta_z     (delta_z),
        .i_out_ready   (i_out_ready),
        .o_free        (merge_free),
        .o_out_valid   (o_out_valid),
        .o_passed      (o_passed),
        .o_failed_axis (o_failed_axis),
        .o_delta_x     (o_delta_x),
        .o_delta_y     (o_delta_y),
        .o_delta_z     (o_delta_z)
    );

    a_clear_after_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVIDE) |=> (r_base_cnt == '0 && r_stim_cnt == '0))
        else $error("counts not cleared after verdict start");

    a_stim_needs_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stim_cnt != '0) |-> (r_base_cnt == CNT_FULL))
        else $error("stimulated word counted before baseline complete");

    a_verdict_from_judge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_JUDGE))
        else $error("verdict appeared outside the judge stage");

    a_pass_matches_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_passed == (o_failed_axis == FAIL_NONE)))
        else $error("pass flag disagrees with failing axis");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the magnetometer self-test checker: random sample words, predicted verdicts.
`timescale 1ns / 1ps

module testbench;
    import mstc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 130;

    typedef enum logic {
        KIND_BASE = 1'b0,
        KIND_STIM = 1'b1
    } t_sample_kind;

    typedef struct packed {
        logic                            passed;
        logic [1:0]                      failed_axis;
        logic [AXES-1:0][DELTA_W-1:0]    delta;      // [0] X, [1] Y, [2] Z
    } t_verdict;

    // Tracks the sums and limits, predicts each verdict and checks it on arrival.
    class self_test_tracker;
        logic [LIMIT_W-1:0]          lim_min_xy, lim_max_xy, lim_min_z, lim_max_z;
        logic signed [SUM_W-1:0]     base_sum [AXES];
        logic signed [SUM_W-1:0]     stim_sum [AXES];
        int                          base_cnt, stim_cnt;
        t_verdict                    verdicts_due [$];
        int                          errors, samples_seen, verdicts_checked, passes_checked;

        function new();
            lim_min_xy = MIN_XY_RST;
            lim_max_xy = MAX_XY_RST;
            lim_min_z  = MIN_Z_RST;
            lim_max_z  = MAX_Z_RST;
            clear_sums();
        endfunction

        function void clear_sums();
            for (int a = 0; a < AXES; a++) begin
                base_sum[a] = '0;
                stim_sum[a] = '0;
            end
            base_cnt = 0;
            stim_cnt = 0;
        endfunction

        function void set_limit(logic [1:0] idx, logic [LIMIT_W-1:0] val);
            case (idx)
                REG_MIN_XY: lim_min_xy = val;
                REG_MAX_XY: lim_max_xy = val;
                REG_MIN_Z:  lim_min_z  = val;
                REG_MAX_Z:  lim_max_z  = val;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return verdicts_due.size();
        endfunction

        function void note_sample(logic kind, logic signed [SAMPLE_W-1:0] x,
                                  logic signed [SAMPLE_W-1:0] y,
                                  logic signed [SAMPLE_W-1:0] z);
            logic signed [SAMPLE_W-1:0] s [AXES];
            logic [1:0]                 axis_code [AXES];
            logic [LIMIT_W-1:0]         lo, hi;
            t_verdict                   v;
            int                         diff;
            s[0] = x;
            s[1] = y;
            s[2] = z;
            axis_code[0] = FAIL_X;
            axis_code[1] = FAIL_Y;
            axis_code[2] = FAIL_Z;
            samples_seen++;
            if (kind == KIND_BASE) begin
                if (base_cnt < SAMPLES) begin
                    for (int a = 0; a < AXES; a++) base_sum[a] += s[a];
                    base_cnt++;
                end
                return;
            end
            // stimulated words count only once the baseline is full
            if (base_cnt < SAMPLES || stim_cnt >= SAMPLES) return;
            for (int a = 0; a < AXES; a++) stim_sum[a] += s[a];
            stim_cnt++;
            if (stim_cnt < SAMPLES) return;

            v.failed_axis = FAIL_NONE;
            for (int a = 0; a < AXES; a++) begin
                // signed divide truncates toward zero
                diff = stim_sum[a] / SAMPLES - base_sum[a] / SAMPLES;
                if (diff < 0) diff = -diff;
                v.delta[a] = diff[DELTA_W-1:0];
                lo = (a == 2) ? lim_min_z : lim_min_xy;
                hi = (a == 2) ? lim_max_z : lim_max_xy;
                if (v.failed_axis == FAIL_NONE && !(v.delta[a] >= lo && v.delta[a] <= hi))
                    v.failed_axis = axis_code[a];
            end
            v.passed = (v.failed_axis == FAIL_NONE);
            verdicts_due.push_back(v);
            clear_sums();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_verdict(t_verdict got);
            t_verdict want;
            int       a;
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("verdict word with none due (passed=%0b axis=%0d)",
                                          got.passed, got.failed_axis));
                return;
            end
            want = verdicts_due.pop_front();
            verdicts_checked++;
            if (want.passed) passes_checked++;
            if (got.passed !== want.passed)
                report_mismatch($sformatf("passed %0b, want %0b", got.passed, want.passed));
            if (got.failed_axis !== want.failed_axis)
                report_mismatch($sformatf("failed_axis %0d, want %0d",
                                          got.failed_axis, want.failed_axis));
            for (a = 0; a < AXES; a++)
                if (got.delta[a] !== want.delta[a])
                    report_mismatch($sformatf("delta axis %0d = %0d, want %0d",
                                              a, got.delta[a], want.delta[a]));
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [1:0]                 i_cfg_idx = REG_MIN_XY;
    logic [LIMIT_W-1:0]         i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_kind = KIND_BASE;
    logic signed [SAMPLE_W-1:0] i_x_sample = '0;
    logic signed [SAMPLE_W-1:0] i_y_sample = '0;
    logic signed [SAMPLE_W-1:0] i_z_sample = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b1;
    logic                       o_passed;
    logic [1:0]                 o_failed_axis;
    logic [DELTA_W-1:0]         o_delta_x, o_delta_y, o_delta_z;

    self_test_tracker sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int settings_run = 1;

    magnetometer_self_test_checker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_x_sample    (i_x_sample),
        .i_y_sample    (i_y_sample),
        .i_z_sample    (i_z_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_passed      (o_passed),
        .o_failed_axis (o_failed_axis),
        .o_delta_x     (o_delta_x),
        .o_delta_y     (o_delta_y),
        .o_delta_z     (o_delta_z)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // verdict side: check on handshake, then pick next cycle's ready
    always @(posedge i_clk) begin
        t_verdict got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.passed      = o_passed;
            got.failed_axis = o_failed_axis;
            got.delta[0]    = o_delta_x;
            got.delta[1]    = o_delta_y;
            got.delta[2]    = o_delta_z;
            sb.check_verdict(got);
        end
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] clamp16(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[SAMPLE_W-1:0];
    endfunction

    // Holds the word on the bus until taken; random idle cycles before it.
    task automatic send_sample(input logic kind, input logic signed [SAMPLE_W-1:0] x,
                               input logic signed [SAMPLE_W-1:0] y,
                               input logic signed [SAMPLE_W-1:0] z);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_x_sample <= x;
        i_y_sample <= y;
        i_z_sample <= z;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample(kind, x, y, z);
    endtask

    task automatic send_random(input logic kind);
        send_sample(kind, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Let every due verdict arrive, then wait out any word still in flight.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [LIMIT_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_limit(idx, val);
    endtask

    task automatic set_limits(input logic [LIMIT_W-1:0] min_xy, max_xy, min_z, max_z);
        drain();
        write_reg(REG_MIN_XY, min_xy);
        write_reg(REG_MAX_XY, max_xy);
        write_reg(REG_MIN_Z, min_z);
        write_reg(REG_MAX_Z, max_z);
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    task automatic random_limits();
        int lo_xy, lo_z;
        lo_xy = $urandom_range(40000);
        lo_z  = $urandom_range(40000);
        set_limits(LIMIT_W'(lo_xy), LIMIT_W'(lo_xy + int'($urandom_range(25000))),
                   LIMIT_W'(lo_z), LIMIT_W'(lo_z + int'($urandom_range(25000))));
    endtask

    // One self-test: baseline words, then stimulated words, with stray words mixed in, or a run of noise words.
    // Aimed tests put each axis shift on its window edges, just outside them, or inside the window.
    task automatic run_self_test(output int counted);
        int  center_b [AXES];
        int  center_s [AXES];
        int  lo, hi, d, tmp, pick;
        bit  aimed, noisy;
        logic signed [SAMPLE_W-1:0] v [AXES];
        pick  = $urandom_range(99);
        aimed = (pick < 55);
        noisy = (pick < 28);
        if (pick >= 80) begin
            // noise: random kinds and values, possibly ending a test mid-way
            counted = $urandom_range(12, 4);
            repeat (counted) send_random(1'($urandom_range(1)));
            return;
        end
        for (int a = 0; a < AXES; a++) begin
            lo = (a == 2) ? int'(sb.lim_min_z) : int'(sb.lim_min_xy);
            hi = (a == 2) ? int'(sb.lim_max_z) : int'(sb.lim_max_xy);
            if (lo > hi) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            case ($urandom_range(5))
                0:       d = lo;
                1:       d = hi;
                2:       d = lo - 1;
                3:       d = hi + 1;
                default: d = $urandom_range(hi, lo);
            endcase
            if (d < 0) d = 0;
            if (d > 65535) d = 65535;
            center_b[a] = int'($urandom_range(65535 - d)) - 32768;
            center_s[a] = center_b[a] + d;
            if ($urandom_range(1)) begin
                tmp         = center_b[a];
                center_b[a] = center_s[a];
                center_s[a] = tmp;
            end
        end
        for (int i = 0; i < SAMPLES; i++) begin
            if ($urandom_range(11) == 0) send_random(KIND_STIM);
            for (int a = 0; a < AXES; a++)
                v[a] = aimed ? clamp16(center_b[a] + (noisy ? int'($urandom_range(4)) - 2 : 0))
                             : 16'($urandom);
            send_sample(KIND_BASE, v[0], v[1], v[2]);
        end
        if ($urandom_range(5) == 0) repeat ($urandom_range(2, 1)) send_random(KIND_BASE);
        for (int i = 0; i < SAMPLES; i++) begin
            for (int a = 0; a < AXES; a++)
                v[a] = aimed ? clamp16(center_s[a] + (noisy ? int'($urandom_range(4)) - 2 : 0))
                             : 16'($urandom);
            send_sample(KIND_STIM, v[0], v[1], v[2]);
        end
        counted = 2 * SAMPLES;
    endtask

    task automatic random_phase(input int idle_pct, input int stall);
        int done, n;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        done          = 0;
        while (done < PHASE_ITEMS) begin
            run_self_test(n);
            done += n;
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: early stimulated word, full-scale swing, extra baseline,
        // then a pass sitting exactly on the window edges
        send_sample(KIND_STIM, 16'sh7FFF, 16'sh8000, 16'sh0000);
        repeat (SAMPLES) send_sample(KIND_BASE, 16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(KIND_BASE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        repeat (SAMPLES) send_sample(KIND_STIM, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        // X baseline sums to -3: average must truncate to 0, not -1
        for (int i = 0; i < SAMPLES; i++)
            send_sample(KIND_BASE, (i < 3) ? -16'sd1 : 16'sd0, 16'sd0, 16'sh7FFF);
        repeat (SAMPLES) send_sample(KIND_STIM, 16'sd2281, -16'sd6843, 16'sd30486);

        random_phase(0, 0);
        set_limits(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        random_phase(60, 0);
        // inverted windows: every axis fails
        set_limits(16'd5000, 16'd100, 16'd3000, 16'd2999);
        random_phase(0, 60);
        random_limits();
        random_phase(11, 11);
        set_limits(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        random_phase(0, 0);
        random_limits();
        random_phase(60, 60);

        drain();
        $display("%0d sample words taken, %0d verdicts checked (%0d passing)",
                 sb.samples_seen, sb.verdicts_checked, sb.passes_checked);
        $display("%0d limit settings used, %0d mismatches", settings_run, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
